/* sv/mvn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_pkg
// Shared types and constants of the mesh vertex normal engine.
// ----------------------------------------------------------------------------
package mvn_pkg;

   // field widths
   localparam int IDX_W = 10;
   localparam int POS_W = 24;
   localparam int EDGE_W = 25;
   localparam int PROD_W = 50;
   localparam int ACC_W = 32;
   localparam int NRM_W = 16;
   localparam int VEC_W = 51;
   localparam int L2_W = 50;
   localparam int ROOT_W = 25;

   // request kinds as they arrive on the port
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_FACET = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   // classified operations handed to the back end
   localparam logic [2:0] OP_LOAD      = 3'd0;
   localparam logic [2:0] OP_FACET     = 3'd1;
   localparam logic [2:0] OP_QUERY     = 3'd2;
   localparam logic [2:0] OP_BAD_FACET = 3'd3;
   localparam logic [2:0] OP_BAD_QUERY = 3'd4;

   // largest squared length of a face's cross product still treated as degenerate
   localparam logic [L2_W-1:0] DEGEN_L2_MAX = L2_W'(28147);

   // request queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   typedef struct packed {
      logic [2:0]              op;
      logic [IDX_W-1:0]        idx_a;
      logic [IDX_W-1:0]        idx_b;
      logic [IDX_W-1:0]        idx_c;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
   } item_type;

   typedef struct packed {
      logic start;
      logic face;
   } norm_ctl_type;

   typedef struct packed {
      logic done;
      logic degen;
   } norm_sts_type;

endpackage

/* sv/mvn_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_front
// Accepts requests, classifies them by kind and index range, and queues
// the ones that need work in the back end.
// ----------------------------------------------------------------------------
module mvn_front #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_kind,
   input  logic [mvn_pkg::IDX_W-1:0]         req_vertex_index,
   input  logic signed [mvn_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [mvn_pkg::POS_W-1:0]  req_pos_y,
   input  logic signed [mvn_pkg::POS_W-1:0]  req_pos_z,
   input  logic [mvn_pkg::IDX_W-1:0]         req_corner_a,
   input  logic [mvn_pkg::IDX_W-1:0]         req_corner_b,
   input  logic [mvn_pkg::IDX_W-1:0]         req_corner_c,
   output logic                              q_valid,
   output mvn_pkg::item_type                 q_item,
   input  logic                              q_pop
);
   import mvn_pkg::*;

   item_type            fifo_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   item_type            cls_item;
   logic                keep;
   logic                push;
   logic                pop;
   logic                vi_ok, a_ok, b_ok, c_ok;

   // index range checks
   assign vi_ok = 32'(req_vertex_index) < 32'(MAX_VERTICES);
   assign a_ok  = 32'(req_corner_a) < 32'(MAX_VERTICES);
   assign b_ok  = 32'(req_corner_b) < 32'(MAX_VERTICES);
   assign c_ok  = 32'(req_corner_c) < 32'(MAX_VERTICES);

   // classify the request
   always_comb begin
      cls_item.idx_a = req_vertex_index;
      cls_item.idx_b = req_corner_b;
      cls_item.idx_c = req_corner_c;
      cls_item.pos_x = req_pos_x;
      cls_item.pos_y = req_pos_y;
      cls_item.pos_z = req_pos_z;
      cls_item.op    = OP_LOAD;
      keep           = 1'b0;
      case (req_kind)
         KIND_LOAD: begin
            cls_item.op = OP_LOAD;
            keep        = vi_ok;
         end
         KIND_FACET: begin
            cls_item.idx_a = req_corner_a;
            cls_item.op    = (a_ok && b_ok && c_ok) ? OP_FACET : OP_BAD_FACET;
            keep           = 1'b1;
         end
         KIND_QUERY: begin
            cls_item.op = vi_ok ? OP_QUERY : OP_BAD_QUERY;
            keep        = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign push      = req_valid && req_ready && keep;
   assign q_valid   = count_ff != '0;
   assign pop       = q_pop && q_valid;
   assign q_item    = fifo_mem[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= cls_item;
      end
   end

endmodule

/* sv/mvn_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_norm
// Multi-cycle vector normalizer: scale-down shift, sum of squares on one
// multiplier, bit-serial square root and restoring division per component.
// ----------------------------------------------------------------------------
module mvn_norm #(
   parameter int NORMAL_FRAC_BITS = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mvn_pkg::norm_ctl_type             ctl,
   input  logic signed [mvn_pkg::VEC_W-1:0]  vec_x,
   input  logic signed [mvn_pkg::VEC_W-1:0]  vec_y,
   input  logic signed [mvn_pkg::VEC_W-1:0]  vec_z,
   output mvn_pkg::norm_sts_type             sts,
   output logic signed [mvn_pkg::NRM_W-1:0]  n_x,
   output logic signed [mvn_pkg::NRM_W-1:0]  n_y,
   output logic signed [mvn_pkg::NRM_W-1:0]  n_z
);
   import mvn_pkg::*;

   localparam int QB = NORMAL_FRAC_BITS + 2;
   localparam int RW = ROOT_W + QB;
   localparam int CNT_W = 6;

   localparam logic [2:0] N_IDLE  = 3'd0;
   localparam logic [2:0] N_SHIFT = 3'd1;
   localparam logic [2:0] N_SQ    = 3'd2;
   localparam logic [2:0] N_CHK   = 3'd3;
   localparam logic [2:0] N_ROOT  = 3'd4;
   localparam logic [2:0] N_DLD   = 3'd5;
   localparam logic [2:0] N_DIV   = 3'd6;
   localparam logic [2:0] N_DONE  = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [VEC_W-1:0]    mag_ff [3];
   logic [VEC_W-1:0]    mag_in [3];
   logic [2:0]          neg_ff, neg_in;
   logic                face_ff, face_in;
   logic                shifted_ff, shifted_in;
   logic [47:0]         sq_ff, sq_in;
   logic [L2_W-1:0]     l2_ff, l2_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [L2_W-1:0]     rad_ff, rad_in;
   logic [L2_W-1:0]     root_ff, root_in;
   logic [L2_W-1:0]     bit_ff, bit_in;
   logic [1:0]          comp_ff, comp_in;
   logic [RW-1:0]       rem_ff, rem_in;
   logic [RW-1:0]       dvs_ff, dvs_in;
   logic [QB-1:0]       quo_ff, quo_in;
   logic [NRM_W-1:0]    nrm_ff [3];
   logic [NRM_W-1:0]    nrm_in [3];
   logic                degen_ff, degen_in;

   logic                big;
   logic [POS_W-1:0]    sq_src;
   logic [L2_W:0]       trial;
   logic [ROOT_W-1:0]   len;
   logic [POS_W-1:0]    num_src;
   logic                num_neg;
   logic [QB-1:0]       quo_next;
   logic [NRM_W-1:0]    sat_val;
   logic [31:0]         quo_ext;

   assign big = (|mag_ff[0][VEC_W-1:POS_W]) || (|mag_ff[1][VEC_W-1:POS_W]) ||
                (|mag_ff[2][VEC_W-1:POS_W]);
   assign trial = {1'b0, rad_ff} - {1'b0, root_ff} - {1'b0, bit_ff};
   assign len   = root_ff[ROOT_W-1:0];

   // component selects for the shared multiplier and divider
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    sq_src = mag_ff[0][POS_W-1:0];
         2'd1:    sq_src = mag_ff[1][POS_W-1:0];
         default: sq_src = mag_ff[2][POS_W-1:0];
      endcase
      case (comp_ff)
         2'd0: begin
            num_src = mag_ff[0][POS_W-1:0];
            num_neg = neg_ff[0];
         end
         2'd1: begin
            num_src = mag_ff[1][POS_W-1:0];
            num_neg = neg_ff[1];
         end
         default: begin
            num_src = mag_ff[2][POS_W-1:0];
            num_neg = neg_ff[2];
         end
      endcase
   end

   // quotient bit and saturation of the finished quotient
   always_comb begin
      if (rem_ff >= dvs_ff) begin
         quo_next = {quo_ff[QB-2:0], 1'b1};
      end else begin
         quo_next = {quo_ff[QB-2:0], 1'b0};
      end
      quo_ext = 32'(quo_next);
      if (num_neg) begin
         if (quo_ext > 32'd32768) begin
            sat_val = 16'h8000;
         end else begin
            sat_val = 16'(32'd0 - quo_ext);
         end
      end else begin
         if (quo_ext > 32'd32767) begin
            sat_val = 16'h7fff;
         end else begin
            sat_val = quo_ext[NRM_W-1:0];
         end
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      face_in    = face_ff;
      shifted_in = shifted_ff;
      sq_in      = sq_ff;
      l2_in      = l2_ff;
      cnt_in     = cnt_ff;
      rad_in     = rad_ff;
      root_in    = root_ff;
      bit_in     = bit_ff;
      comp_in    = comp_ff;
      rem_in     = rem_ff;
      dvs_in     = dvs_ff;
      quo_in     = quo_ff;
      nrm_in     = nrm_ff;
      degen_in   = degen_ff;
      case (state_ff)
         N_IDLE: begin
            if (ctl.start) begin
               neg_in     = {vec_z[VEC_W-1], vec_y[VEC_W-1], vec_x[VEC_W-1]};
               mag_in[0]  = vec_x[VEC_W-1] ? VEC_W'(-vec_x) : VEC_W'(vec_x);
               mag_in[1]  = vec_y[VEC_W-1] ? VEC_W'(-vec_y) : VEC_W'(vec_y);
               mag_in[2]  = vec_z[VEC_W-1] ? VEC_W'(-vec_z) : VEC_W'(vec_z);
               face_in    = ctl.face;
               shifted_in = 1'b0;
               state_in   = N_SHIFT;
            end
         end
         // one right shift per cycle until all magnitudes fit 24 bits
         N_SHIFT: begin
            if (big) begin
               mag_in[0]  = mag_ff[0] >> 1;
               mag_in[1]  = mag_ff[1] >> 1;
               mag_in[2]  = mag_ff[2] >> 1;
               shifted_in = 1'b1;
            end else begin
               cnt_in   = '0;
               l2_in    = '0;
               state_in = N_SQ;
            end
         end
         // square one component per cycle, add in the next
         N_SQ: begin
            sq_in = sq_src * sq_src;
            if (cnt_ff != '0) begin
               l2_in = l2_ff + L2_W'(sq_ff);
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(3)) begin
               state_in = N_CHK;
            end
         end
         N_CHK: begin
            if (!shifted_ff && (face_ff ? (l2_ff <= DEGEN_L2_MAX) : (l2_ff == '0))) begin
               nrm_in[0] = '0;
               nrm_in[1] = '0;
               nrm_in[2] = '0;
               degen_in  = 1'b1;
               state_in  = N_DONE;
            end else begin
               rad_in   = l2_ff;
               root_in  = '0;
               bit_in   = L2_W'(1) << (L2_W - 2);
               cnt_in   = CNT_W'(ROOT_W);
               state_in = N_ROOT;
            end
         end
         // digit-by-digit integer square root, one result bit per cycle
         N_ROOT: begin
            if (!trial[L2_W]) begin
               rad_in  = trial[L2_W-1:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               comp_in  = '0;
               state_in = N_DLD;
            end
         end
         // load the rounded numerator of one component
         N_DLD: begin
            rem_in   = (RW'(num_src) << NORMAL_FRAC_BITS) + RW'(len >> 1);
            dvs_in   = RW'(len) << (QB - 1);
            quo_in   = '0;
            cnt_in   = CNT_W'(QB);
            state_in = N_DIV;
         end
         // restoring division, one quotient bit per cycle
         N_DIV: begin
            if (rem_ff >= dvs_ff) begin
               rem_in = rem_ff - dvs_ff;
            end
            quo_in = quo_next;
            dvs_in = dvs_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               nrm_in[comp_ff] = sat_val;
               if (comp_ff == 2'd2) begin
                  degen_in = 1'b0;
                  state_in = N_DONE;
               end else begin
                  comp_in  = comp_ff + 1'b1;
                  state_in = N_DLD;
               end
            end
         end
         N_DONE: begin
            state_in = N_IDLE;
         end
         default: begin
            state_in = N_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      face_ff    <= face_in;
      shifted_ff <= shifted_in;
      sq_ff      <= sq_in;
      l2_ff      <= l2_in;
      cnt_ff     <= cnt_in;
      rad_ff     <= rad_in;
      root_ff    <= root_in;
      bit_ff     <= bit_in;
      comp_ff    <= comp_in;
      rem_ff     <= rem_in;
      dvs_ff     <= dvs_in;
      quo_ff     <= quo_in;
      nrm_ff     <= nrm_in;
      degen_ff   <= degen_in;
   end

   assign sts.done  = state_ff == N_DONE;
   assign sts.degen = degen_ff;
   assign n_x = nrm_ff[0];
   assign n_y = nrm_ff[1];
   assign n_z = nrm_ff[2];

endmodule

/* sv/mvn_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_back
// Executes queued requests: position and accumulator memories, edge and
// cross product on one shared multiplier, normalizer, and the result register.
// ----------------------------------------------------------------------------
module mvn_back #(
   parameter int MAX_VERTICES     = 1024,
   parameter int NORMAL_FRAC_BITS = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  mvn_pkg::item_type                 q_item,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [mvn_pkg::NRM_W-1:0]  rsp_normal_x,
   output logic signed [mvn_pkg::NRM_W-1:0]  rsp_normal_y,
   output logic signed [mvn_pkg::NRM_W-1:0]  rsp_normal_z,
   output logic                              rsp_from_vertex,
   output logic                              rsp_degenerate
);
   import mvn_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);

   localparam logic [3:0] B_IDLE = 4'd0;
   localparam logic [3:0] B_QRD  = 4'd1;
   localparam logic [3:0] B_RA   = 4'd2;
   localparam logic [3:0] B_RB   = 4'd3;
   localparam logic [3:0] B_RC   = 4'd4;
   localparam logic [3:0] B_MUL  = 4'd5;
   localparam logic [3:0] B_NST  = 4'd6;
   localparam logic [3:0] B_NORM = 4'd7;
   localparam logic [3:0] B_ACR  = 4'd8;
   localparam logic [3:0] B_ACW  = 4'd9;
   localparam logic [3:0] B_OUT  = 4'd10;

   function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
      logic [31:0] ext;
      ext = 32'(idx);
      return ext[AW-1:0];
   endfunction

   // memories
   logic [3*POS_W-1:0]  pos_mem [MAX_VERTICES];
   logic [3*ACC_W-1:0]  acc_mem [MAX_VERTICES];
   logic [3*POS_W-1:0]  pos_rd_ff;
   logic [3*ACC_W-1:0]  acc_rd_ff;
   logic [AW-1:0]       pos_raddr, acc_raddr, acc_waddr;
   logic                pos_we, acc_we;
   logic [3*ACC_W-1:0]  acc_wdata;

   logic [3:0]               state_ff, state_in;
   item_type                 item_ff, item_in;
   logic signed [POS_W-1:0]  ax_ff, ay_ff, az_ff;
   logic signed [POS_W-1:0]  ax_in, ay_in, az_in;
   logic signed [EDGE_W-1:0] e1x_ff, e1y_ff, e1z_ff, e2x_ff, e2y_ff, e2z_ff;
   logic signed [EDGE_W-1:0] e1x_in, e1y_in, e1z_in, e2x_in, e2y_in, e2z_in;
   logic signed [PROD_W-1:0] p_ff, p_in, first_ff, first_in;
   logic signed [VEC_W-1:0]  vx_ff, vy_ff, vz_ff, vx_in, vy_in, vz_in;
   logic [2:0]               cnt_ff, cnt_in;
   logic [1:0]               k_ff, k_in;
   logic signed [NRM_W-1:0]  nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;
   logic                     degen_ff, degen_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [NRM_W-1:0]  rsp_nx_ff, rsp_ny_ff, rsp_nz_ff;
   logic signed [NRM_W-1:0]  rsp_nx_in, rsp_ny_in, rsp_nz_in;
   logic                     rsp_fv_ff, rsp_fv_in, rsp_dg_ff, rsp_dg_in;

   logic signed [POS_W-1:0]  rd_x, rd_y, rd_z;
   logic signed [EDGE_W-1:0] opa, opb;
   logic [IDX_W-1:0]         corner;
   logic [ACC_W-1:0]         sum_x, sum_y, sum_z;
   logic                     slot_free;
   norm_ctl_type             nctl;
   norm_sts_type             nsts;
   logic signed [NRM_W-1:0]  nn_x, nn_y, nn_z;

   assign rd_x = pos_rd_ff[3*POS_W-1:2*POS_W];
   assign rd_y = pos_rd_ff[2*POS_W-1:POS_W];
   assign rd_z = pos_rd_ff[POS_W-1:0];
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // multiplier operands for the six cross product terms
   always_comb begin
      case (cnt_ff)
         3'd0: begin opa = e1y_ff; opb = e2z_ff; end
         3'd1: begin opa = e1z_ff; opb = e2y_ff; end
         3'd2: begin opa = e1z_ff; opb = e2x_ff; end
         3'd3: begin opa = e1x_ff; opb = e2z_ff; end
         3'd4: begin opa = e1x_ff; opb = e2y_ff; end
         default: begin opa = e1y_ff; opb = e2x_ff; end
      endcase
      case (k_ff)
         2'd0:    corner = item_ff.idx_a;
         2'd1:    corner = item_ff.idx_b;
         default: corner = item_ff.idx_c;
      endcase
   end

   // accumulator update with the sign-extended face normal
   assign sum_x = acc_rd_ff[3*ACC_W-1:2*ACC_W] + ACC_W'(nx_ff);
   assign sum_y = acc_rd_ff[2*ACC_W-1:ACC_W] + ACC_W'(ny_ff);
   assign sum_z = acc_rd_ff[ACC_W-1:0] + ACC_W'(nz_ff);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      ax_in = ax_ff; ay_in = ay_ff; az_in = az_ff;
      e1x_in = e1x_ff; e1y_in = e1y_ff; e1z_in = e1z_ff;
      e2x_in = e2x_ff; e2y_in = e2y_ff; e2z_in = e2z_ff;
      p_in      = p_ff;
      first_in  = first_ff;
      vx_in = vx_ff; vy_in = vy_ff; vz_in = vz_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      nx_in = nx_ff; ny_in = ny_ff; nz_in = nz_ff;
      degen_in  = degen_ff;
      q_pop     = 1'b0;
      pos_we    = 1'b0;
      acc_we    = 1'b0;
      pos_raddr = to_addr(q_item.idx_a);
      acc_raddr = to_addr(q_item.idx_a);
      acc_waddr = to_addr(q_item.idx_a);
      acc_wdata = '0;
      nctl.start = 1'b0;
      nctl.face  = item_ff.op == OP_FACET;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_nx_in = rsp_nx_ff; rsp_ny_in = rsp_ny_ff; rsp_nz_in = rsp_nz_ff;
      rsp_fv_in = rsp_fv_ff; rsp_dg_in = rsp_dg_ff;
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               case (q_item.op)
                  OP_LOAD: begin
                     pos_we = 1'b1;
                     acc_we = 1'b1;
                  end
                  OP_QUERY: begin
                     state_in = B_QRD;
                  end
                  OP_FACET: begin
                     state_in = B_RA;
                  end
                  default: begin
                     nx_in = '0; ny_in = '0; nz_in = '0;
                     degen_in = 1'b1;
                     state_in = B_OUT;
                  end
               endcase
            end
         end
         B_QRD: begin
            vx_in = VEC_W'($signed(acc_rd_ff[3*ACC_W-1:2*ACC_W]));
            vy_in = VEC_W'($signed(acc_rd_ff[2*ACC_W-1:ACC_W]));
            vz_in = VEC_W'($signed(acc_rd_ff[ACC_W-1:0]));
            state_in = B_NST;
         end
         // corner positions arrive one per cycle
         B_RA: begin
            ax_in = rd_x; ay_in = rd_y; az_in = rd_z;
            pos_raddr = to_addr(item_ff.idx_b);
            state_in = B_RB;
         end
         B_RB: begin
            e1x_in = EDGE_W'(rd_x) - EDGE_W'(ax_ff);
            e1y_in = EDGE_W'(rd_y) - EDGE_W'(ay_ff);
            e1z_in = EDGE_W'(rd_z) - EDGE_W'(az_ff);
            pos_raddr = to_addr(item_ff.idx_c);
            state_in = B_RC;
         end
         B_RC: begin
            e2x_in = EDGE_W'(rd_x) - EDGE_W'(ax_ff);
            e2y_in = EDGE_W'(rd_y) - EDGE_W'(ay_ff);
            e2z_in = EDGE_W'(rd_z) - EDGE_W'(az_ff);
            cnt_in = '0;
            state_in = B_MUL;
         end
         // one product per cycle; each component is the difference of a pair of products
         B_MUL: begin
            p_in   = opa * opb;
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff)
               3'd1, 3'd3, 3'd5: first_in = p_ff;
               3'd2: vx_in = VEC_W'(first_ff) - VEC_W'(p_ff);
               3'd4: vy_in = VEC_W'(first_ff) - VEC_W'(p_ff);
               3'd6: begin
                  vz_in = VEC_W'(first_ff) - VEC_W'(p_ff);
                  state_in = B_NST;
               end
               default: first_in = first_ff;
            endcase
         end
         B_NST: begin
            nctl.start = 1'b1;
            state_in = B_NORM;
         end
         B_NORM: begin
            if (nsts.done) begin
               nx_in = nn_x; ny_in = nn_y; nz_in = nn_z;
               degen_in = nsts.degen;
               k_in = '0;
               state_in = (item_ff.op == OP_FACET) ? B_ACR : B_OUT;
            end
         end
         // read-modify-write of each corner accumulator
         B_ACR: begin
            acc_raddr = to_addr(corner);
            state_in = B_ACW;
         end
         B_ACW: begin
            acc_we    = 1'b1;
            acc_waddr = to_addr(corner);
            acc_wdata = {sum_x, sum_y, sum_z};
            if (k_ff == 2'd2) begin
               state_in = B_OUT;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = B_ACR;
            end
         end
         B_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_nx_in = nx_ff; rsp_ny_in = ny_ff; rsp_nz_in = nz_ff;
               rsp_dg_in = degen_ff;
               rsp_fv_in = (item_ff.op == OP_QUERY) || (item_ff.op == OP_BAD_QUERY);
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      ax_ff <= ax_in; ay_ff <= ay_in; az_ff <= az_in;
      e1x_ff <= e1x_in; e1y_ff <= e1y_in; e1z_ff <= e1z_in;
      e2x_ff <= e2x_in; e2y_ff <= e2y_in; e2z_ff <= e2z_in;
      p_ff     <= p_in;
      first_ff <= first_in;
      vx_ff <= vx_in; vy_ff <= vy_in; vz_ff <= vz_in;
      cnt_ff <= cnt_in;
      k_ff   <= k_in;
      nx_ff <= nx_in; ny_ff <= ny_in; nz_ff <= nz_in;
      degen_ff  <= degen_in;
      rsp_nx_ff <= rsp_nx_in; rsp_ny_ff <= rsp_ny_in; rsp_nz_ff <= rsp_nz_in;
      rsp_fv_ff <= rsp_fv_in;
      rsp_dg_ff <= rsp_dg_in;
   end

   // position memory
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[to_addr(q_item.idx_a)] <= {q_item.pos_x, q_item.pos_y, q_item.pos_z};
      end
      pos_rd_ff <= pos_mem[pos_raddr];
   end

   // accumulator memory
   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_waddr] <= acc_wdata;
      end
      acc_rd_ff <= acc_mem[acc_raddr];
   end

   mvn_norm #(
      .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
   ) u_norm (
      .clock (clock),
      .reset (reset),
      .ctl   (nctl),
      .vec_x (vx_ff),
      .vec_y (vy_ff),
      .vec_z (vz_ff),
      .sts   (nsts),
      .n_x   (nn_x),
      .n_y   (nn_y),
      .n_z   (nn_z)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_normal_x    = rsp_nx_ff;
   assign rsp_normal_y    = rsp_ny_ff;
   assign rsp_normal_z    = rsp_nz_ff;
   assign rsp_from_vertex = rsp_fv_ff;
   assign rsp_degenerate  = rsp_dg_ff;

endmodule

/* sv/mesh_vertex_normal_engine.sv */
`timescale 1ns / 1ps
// a load is written to both memories as the back end pops it; a query or a facet
// also runs the normalizer, where each scale-down shift adds to its time
// that time is set by the 25-step square root and three restoring divisions
// in the normalizer; one item is worked at a time
// a 4-entry request queue keeps accepting while the back end is busy, until it is full
// reset clears control state only; position and accumulator memories are not cleared
// ----------------------------------------------------------------------------
// mesh_vertex_normal_engine
// Face normals by cross product and vertex normals by averaging of the
// face normals accumulated at each corner.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_engine #(
   parameter int MAX_VERTICES     = 1024,
   parameter int NORMAL_FRAC_BITS = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_kind,
   input  logic [mvn_pkg::IDX_W-1:0]         req_vertex_index,
   input  logic signed [mvn_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [mvn_pkg::POS_W-1:0]  req_pos_y,
   input  logic signed [mvn_pkg::POS_W-1:0]  req_pos_z,
   input  logic [mvn_pkg::IDX_W-1:0]         req_corner_a,
   input  logic [mvn_pkg::IDX_W-1:0]         req_corner_b,
   input  logic [mvn_pkg::IDX_W-1:0]         req_corner_c,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [mvn_pkg::NRM_W-1:0]  rsp_normal_x,
   output logic signed [mvn_pkg::NRM_W-1:0]  rsp_normal_y,
   output logic signed [mvn_pkg::NRM_W-1:0]  rsp_normal_z,
   output logic                              rsp_from_vertex,
   output logic                              rsp_degenerate
);
   import mvn_pkg::*;

   logic      q_valid;
   logic      q_pop;
   item_type  q_item;

   // request intake and queue
   mvn_front #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_vertex_index (req_vertex_index),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_corner_a     (req_corner_a),
      .req_corner_b     (req_corner_b),
      .req_corner_c     (req_corner_c),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   // execution
   mvn_back #(
      .MAX_VERTICES     (MAX_VERTICES),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_normal_x    (rsp_normal_x),
      .rsp_normal_y    (rsp_normal_y),
      .rsp_normal_z    (rsp_normal_z),
      .rsp_from_vertex (rsp_from_vertex),
      .rsp_degenerate  (rsp_degenerate)
   );

endmodule

/* sv/mvn_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_checker
// Port-level checks of the result channel of the normal engine.
// ----------------------------------------------------------------------------
module mvn_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [mvn_pkg::NRM_W-1:0]  rsp_normal_x,
   input logic signed [mvn_pkg::NRM_W-1:0]  rsp_normal_y,
   input logic signed [mvn_pkg::NRM_W-1:0]  rsp_normal_z,
   input logic                              rsp_from_vertex,
   input logic                              rsp_degenerate
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_normal_x) &&
      $stable(rsp_normal_y) && $stable(rsp_normal_z) &&
      $stable(rsp_from_vertex) && $stable(rsp_degenerate))
      else $error("stalled result changed");

   // degenerate results carry a zero normal
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
      rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate result with nonzero normal");

   // a normalized result is never the zero vector
   a_unit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
      rsp_normal_x != '0 || rsp_normal_y != '0 || rsp_normal_z != '0)
      else $error("normalized result is zero");

endmodule

bind mesh_vertex_normal_engine mvn_checker u_mvn_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_normal_x    (rsp_normal_x),
   .rsp_normal_y    (rsp_normal_y),
   .rsp_normal_z    (rsp_normal_z),
   .rsp_from_vertex (rsp_from_vertex),
   .rsp_degenerate  (rsp_degenerate)
);
